// File: hw/rtl/wrs_pkg.sv
// shared constants, codes and controller/datapath interface types for the weighted selector
package wrs_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W       = 20;
    localparam int RND_W       = 32;
    localparam int DIV_CNT_W   = $clog2(RND_W);
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 32;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SELECT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic append;
        logic res_full;
        logic res_bad;
        logic res_zero;
        logic set_read;
        logic set_write;
        logic div_init;
        logic div_step;
        logic walk_read;
        logic walk_check;
        logic out_load;
    } dp_ctrl_t;

    // status from datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             bad_index;
        logic             total_zero;
        logic             div_last;
        logic             walk_end;
        logic             walk_hit;
    } dp_stat_t;

endpackage

// File: hw/rtl/wrs_ram.sv
// generic single-port-write ram with registered read
module wrs_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/wrs_datapath.sv
// weight table, running total, bit-serial modulo and table walk
module wrs_datapath
    import wrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_ctrl_t               ctrl,
    input  logic [CMD_W-1:0]       in_cmd,
    input  logic [WEIGHT_BITS-1:0] in_weight,
    input  logic [IDX_W-1:0]       in_index,
    input  logic [RND_W-1:0]       in_random,
    output dp_stat_t               stat,
    output logic [IDX_W-1:0]       out_chosen,
    output logic [STATUS_W-1:0]    out_status,
    output logic [SUM_W-1:0]       out_sum
);

    logic [CMD_W-1:0]       cmd_reg;
    logic [WEIGHT_BITS-1:0] weight_reg;
    logic [IDX_W-1:0]       index_reg;
    logic [RND_W-1:0]       rnd_reg;
    logic [SUM_W-1:0]       rem_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [CNT_W-1:0]       walk_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [SUM_W-1:0]       total_reg;
    logic [SUM_W-1:0]       total_next;
    logic [IDX_W-1:0]       chosen_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [IDX_W-1:0]       out_chosen_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [SUM_W-1:0]       out_sum_reg;

    logic [SUM_W:0]         trial;
    logic [SUM_W:0]         trial_diff;
    logic [SUM_W-1:0]       rem_div;
    logic [CNT_W-1:0]       walk_dec;
    logic [SUM_W-1:0]       rd_weight;

    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    logic [WEIGHT_BITS-1:0] ram_rd_data;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;

    // one restoring division step: shift in the next dividend bit
    assign trial      = {rem_reg, rnd_reg[RND_W-1]};
    assign trial_diff = trial - {1'b0, total_reg};
    assign rem_div    = (trial >= {1'b0, total_reg}) ? trial_diff[SUM_W-1:0]
                                                     : trial[SUM_W-1:0];

    assign walk_dec  = walk_reg - 1'b1;
    assign rd_weight = {{(SUM_W - WEIGHT_BITS){1'b0}}, ram_rd_data};

    assign ram_wr_en   = ctrl.append || ctrl.set_write;
    assign ram_wr_addr = ctrl.append ? count_reg[IDX_W-1:0] : index_reg;
    assign ram_rd_en   = ctrl.set_read || ctrl.walk_read;
    assign ram_rd_addr = ctrl.set_read ? index_reg : walk_dec[IDX_W-1:0];

    wrs_ram #(
        .DATA_W (WEIGHT_BITS),
        .DEPTH  (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (weight_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        if (ctrl.append)
        begin
            count_next = count_reg + 1'b1;
            total_next = total_reg + {{(SUM_W - WEIGHT_BITS){1'b0}}, weight_reg};
        end
        else if (ctrl.set_write)
        begin
            total_next = total_reg - rd_weight
                         + {{(SUM_W - WEIGHT_BITS){1'b0}}, weight_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg    <= in_cmd;
            weight_reg <= in_weight;
            index_reg  <= in_index;
            rnd_reg    <= in_random;
            chosen_reg <= '0;
            status_reg <= ST_OK;
        end
        if (ctrl.res_full)
        begin
            status_reg <= ST_FULL;
        end
        if (ctrl.res_bad)
        begin
            status_reg <= ST_BAD_INDEX;
        end
        if (ctrl.res_zero)
        begin
            status_reg <= ST_ZERO;
        end
        if (ctrl.div_init)
        begin
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            walk_reg    <= count_reg;
        end
        if (ctrl.div_step)
        begin
            rem_reg     <= rem_div;
            rnd_reg     <= {rnd_reg[RND_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (ctrl.walk_read)
        begin
            walk_reg <= walk_dec;
        end
        if (ctrl.walk_check)
        begin
            if (stat.walk_hit)
            begin
                chosen_reg <= walk_reg[IDX_W-1:0];
            end
            else
            begin
                rem_reg <= rem_reg - rd_weight;
            end
        end
        if (ctrl.out_load)
        begin
            out_chosen_reg <= chosen_reg;
            out_status_reg <= status_reg;
            out_sum_reg    <= total_reg;
        end
    end

    assign stat.cmd        = cmd_reg;
    assign stat.full       = (count_reg == CNT_W'(MAX_ENTRIES));
    assign stat.bad_index  = ({{(CNT_W - IDX_W){1'b0}}, index_reg} >= count_reg);
    assign stat.total_zero = (total_reg == '0);
    assign stat.div_last   = (div_cnt_reg == DIV_CNT_W'(RND_W - 1));
    assign stat.walk_end   = (walk_reg == '0);
    assign stat.walk_hit   = (ram_rd_data != '0) && (rem_reg < rd_weight);

    assign out_chosen = out_chosen_reg;
    assign out_status = out_status_reg;
    assign out_sum    = out_sum_reg;

endmodule

// File: hw/rtl/wrs_ctrl.sv
// command sequencer and stream handshake control
module wrs_ctrl
    import wrs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl,
    output logic     in_ready,
    output logic     out_valid
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DISPATCH  = 3'd1;
    localparam logic [2:0] S_SET_WRITE = 3'd2;
    localparam logic [2:0] S_DIVIDE    = 3'd3;
    localparam logic [2:0] S_WALK_READ = 3'd4;
    localparam logic [2:0] S_WALK_CHK  = 3'd5;
    localparam logic [2:0] S_FINISH    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FINISH;
                case (stat.cmd)
                    CMD_APPEND:
                    begin
                        if (stat.full)
                        begin
                            ctrl.res_full = 1'b1;
                        end
                        else
                        begin
                            ctrl.append = 1'b1;
                        end
                    end
                    CMD_SET:
                    begin
                        if (stat.bad_index)
                        begin
                            ctrl.res_bad = 1'b1;
                        end
                        else
                        begin
                            ctrl.set_read = 1'b1;
                            state_next    = S_SET_WRITE;
                        end
                    end
                    CMD_SELECT:
                    begin
                        if (stat.total_zero)
                        begin
                            ctrl.res_zero = 1'b1;
                        end
                        else
                        begin
                            ctrl.div_init = 1'b1;
                            state_next    = S_DIVIDE;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SET_WRITE:
            begin
                ctrl.set_write = 1'b1;
                state_next     = S_FINISH;
            end
            S_DIVIDE:
            begin
                ctrl.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_WALK_READ;
                end
            end
            S_WALK_READ:
            begin
                if (stat.walk_end)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    ctrl.walk_read = 1'b1;
                    state_next     = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                ctrl.walk_check = 1'b1;
                state_next      = stat.walk_hit ? S_FINISH : S_WALK_READ;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: hw/rtl/weighted_random_selector.sv
// top level of the weighted random (roulette wheel) selector
//
// channel   dir  fields (lsb first)
// --------  ---  ---------------------------------------------------------
// s_axis    in   cmd[1:0] weight[17:2] entry_index[21:18] random_word[53:22]
// m_axis    out  chosen_index[3:0] status[5:4] weight_sum[25:6]
//
// one command is in flight at a time; s_tready is high only while the sequencer idles
// append, bad set, full table, zero total and unknown commands: dispatch, then the finish state
// set: one extra state that writes after the registered read of the old weight
// select: a 32-step bit-serial modulo, then
//   one table read plus one compare per entry walked, at most 16 entries
// the result sits in an output register, so the next transfer is taken while it waits;
//   a stalled m_tready only holds the sequencer in its final state
// reset clears entry count, running total and handshake state; table contents need none
module weighted_random_selector
    import wrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cmd, weight, entry_index, random_word, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // chosen_index, status, weight_sum, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    dp_ctrl_t            ctrl;
    dp_stat_t            stat;
    logic [IDX_W-1:0]    out_chosen;
    logic [STATUS_W-1:0] out_status;
    logic [SUM_W-1:0]    out_sum;

    // sequencer: handshakes and step order
    wrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .ctrl      (ctrl),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    // table, total, modulo and walk
    wrs_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .in_cmd     (s_tdata[1:0]),
        .in_weight  (s_tdata[17:2]),
        .in_index   (s_tdata[21:18]),
        .in_random  (s_tdata[53:22]),
        .stat       (stat),
        .out_chosen (out_chosen),
        .out_status (out_status),
        .out_sum    (out_sum)
    );

    // pack the result, upper bits zero
    assign m_tdata = {{(OUT_DATA_W - SUM_W - STATUS_W - IDX_W){1'b0}},
                      out_sum, out_status, out_chosen};

endmodule
